// File: src/selective_state_space_scan_assert.svh
// selective_state_space_scan_assert.svh: assertion macros for the scan block
// expects clk_i and rst_ni in the scope of each use
`ifndef SELECTIVE_STATE_SPACE_SCAN_ASSERT_SVH
`define SELECTIVE_STATE_SPACE_SCAN_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SSS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define SSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/sss_pkg.sv
// sss_pkg: shared constants, types and helper functions of the scan block
// used by sss_core and selective_state_space_scan, no dependencies
`timescale 1ns / 1ps

package sss_pkg;

  // fixed-point format and sizes
  localparam int FRAC_BITS  = 16;
  localparam int STATE_SIZE = 128;
  localparam int ADDR_W     = (STATE_SIZE > 1) ? $clog2(STATE_SIZE) : 1;
  localparam int IDX_W      = 7;
  localparam int DATA_W     = 32;
  localparam int ACC_W      = 48;
  localparam int MUL_W      = 34;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int V_W        = PROD_W - FRAC_BITS;
  localparam int EXP_TOT    = FRAC_BITS + 30;
  localparam int EXP_TERMS  = 12;
  localparam int LN_TERMS   = 13;
  localparam int DIV_STEPS  = 30;

  // arithmetic constants
  localparam logic signed [MUL_W-1:0] LOG2E_Q30 = 34'sd1549082005;
  localparam logic signed [MUL_W-1:0] LN2_Q30   = 34'sd744261118;
  localparam logic [30:0]             ONE_Q30   = 31'h4000_0000;
  localparam logic [31:0]             POS_MAX   = 32'h7FFF_FFFF;
  localparam logic signed [31:0]      SP_LIMIT  = 32'(20 * (2 ** FRAC_BITS));
  localparam logic signed [V_W-1:0]   EXP_LIM   = V_W'(64 * (2 ** FRAC_BITS));
  localparam logic signed [V_W:0]     SAT32_HI  =
    {{(V_W + 1 - DATA_W){1'b0}}, 1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic signed [V_W:0]     SAT32_LO  =
    {{(V_W + 1 - DATA_W){1'b1}}, 1'b1, {(DATA_W - 1){1'b0}}};
  localparam logic signed [V_W:0]     ACC_HI    =
    {{(V_W + 1 - ACC_W){1'b0}}, 1'b0, {(ACC_W - 1){1'b1}}};
  localparam logic signed [V_W:0]     ACC_LO    =
    {{(V_W + 1 - ACC_W){1'b1}}, 1'b1, {(ACC_W - 1){1'b0}}};

  // operation codes of the input kind
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } operation_e;

  // arithmetic sequencer states
  typedef enum logic [4:0] {
    C_IDLE, C_SP, C_E0, C_E1, C_E2, C_ET, C_EP, C_EC, C_EF, C_ER,
    C_DV, C_LW, C_LW2, C_LD, C_LC, C_LP, C_LR,
    C_X1, C_X2, C_X3, C_N1, C_N2, C_N3, C_N4, C_N5, C_DONE
  } core_state_e;

  // top-level control states
  typedef enum logic [1:0] {
    T_IDLE,
    T_RD,
    T_BUSY,
    T_WAIT
  } top_state_e;

  // operands handed to the arithmetic core
  typedef struct packed {
    logic signed [DATA_W-1:0] dt;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
    logic signed [DATA_W-1:0] prev;
  } sss_operands_t;

  // results returned by the arithmetic core
  typedef struct packed {
    logic signed [DATA_W-1:0] ns;
    logic signed [V_W-1:0]    nc;
  } sss_result_t;

  // floor(2^32 / d) for the small divisors of the series
  function automatic logic [32:0] rcp(input logic [4:0] d);
    logic [32:0] r;
    unique case (d)
      5'd1:    r = 33'd4294967296;
      5'd2:    r = 33'd2147483648;
      5'd3:    r = 33'd1431655765;
      5'd4:    r = 33'd1073741824;
      5'd5:    r = 33'd858993459;
      5'd6:    r = 33'd715827882;
      5'd7:    r = 33'd613566756;
      5'd8:    r = 33'd536870912;
      5'd9:    r = 33'd477218588;
      5'd10:   r = 33'd429496729;
      5'd11:   r = 33'd390451572;
      5'd12:   r = 33'd357913941;
      5'd13:   r = 33'd330382099;
      5'd15:   r = 33'd286331153;
      5'd17:   r = 33'd252645135;
      5'd19:   r = 33'd226050910;
      5'd21:   r = 33'd204522252;
      5'd23:   r = 33'd186737708;
      5'd25:   r = 33'd171798691;
      default: r = 33'd4294967296;
    endcase
    return r;
  endfunction

  // saturate a wide signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [V_W:0] v);
    logic signed [DATA_W-1:0] r;
    priority if (v > SAT32_HI) begin
      r = SAT32_HI[DATA_W-1:0];
    end else if (v < SAT32_LO) begin
      r = SAT32_LO[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: src/selective_state_space_scan.sv
// selective_state_space_scan: top level, stream ports, state memory, accumulator
// depends on sss_pkg, sss_core and selective_state_space_scan_assert.svh
//
// One channel of a selective state-space scan in signed Q16.16.
// Input stream: tuser selects the kind of transaction (0 load, 1 step), tlast
// marks the last state element of a token, tdata carries index and operands.
// A load transaction writes one element of the state memory at acceptance and
// returns nothing. A step transaction reads the element, runs softplus, exp
// and the state update on one shared multiplier, writes the new element back
// and returns one transaction: tdata holds the new state and y, tuser says y
// is valid (last element only, y is zero otherwise).
// A step passes dt straight through softplus when dt is above 20.0, and exp
// skips its series when its argument (-|dt| in softplus, softplus(dt)*A in the
// update) lies outside +-64.0; the exp and ln1p series loop on the single
// multiplier, and ln1p divides with a bit-serial divider. Only one step is
// in flight; the next item can be taken in the cycle after the step finishes,
// even while its result still waits in the output register. When the receiver
// stalls, a finished step holds until the output register frees. Reset clears
// the accumulator and control; the memory is undefined.
`timescale 1ns / 1ps
`include "selective_state_space_scan_assert.svh"

module selective_state_space_scan (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave side
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [199:0] s_axis_tdata,  // state_index, initial_state, dt_raw, x_value,
                                      // decay_coef, b_value, c_value, zero pad
  input  logic         s_axis_tuser,  // operation
  input  logic         s_axis_tlast,  // last_element
  // master side
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // new_state, y_value
  output logic         m_axis_tuser   // y_valid
);

  sss_pkg::top_state_e tstate_q, tstate_d;

  // input field decode
  logic [sss_pkg::IDX_W-1:0]  s_idx;
  logic [sss_pkg::ADDR_W-1:0] s_addr;
  logic                       s_inside, s_acc;
  logic signed [31:0]         s_init;

  // latched step item
  sss_pkg::sss_operands_t     ops_q, core_ops;
  logic [sss_pkg::ADDR_W-1:0] addr_q;
  logic                       inside_q, last_q;

  // state memory
  logic [31:0]                mem [sss_pkg::STATE_SIZE];
  logic [31:0]                rd_q, mem_wdata;
  logic [sss_pkg::ADDR_W-1:0] mem_addr;
  logic                       mem_we;

  // core link
  logic                 core_start, core_done;
  sss_pkg::sss_result_t core_res;

  // finish, accumulator and output
  logic                       out_free, fin;
  logic signed [47:0]         acc_q;
  logic signed [sss_pkg::V_W:0] acc_sum, acc_sat;
  logic [63:0]                m_data_q;
  logic                       m_valid_q, m_user_q;

  assign s_idx    = s_axis_tdata[6:0];
  assign s_init   = s_axis_tdata[38:7];
  assign s_addr   = sss_pkg::ADDR_W'(s_idx);
  assign s_inside = (32'(s_idx) < sss_pkg::STATE_SIZE);
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (tstate_q == sss_pkg::T_IDLE);

  assign out_free = !m_valid_q || m_axis_tready;
  assign fin      = out_free && ((tstate_q == sss_pkg::T_BUSY && core_done) ||
                                 tstate_q == sss_pkg::T_WAIT);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tstate_q <= sss_pkg::T_IDLE;
    end else begin
      tstate_q <= tstate_d;
    end
  end

  always_comb begin
    tstate_d   = tstate_q;
    core_start = 1'b0;
    unique case (tstate_q)
      sss_pkg::T_IDLE: begin
        if (s_acc && sss_pkg::operation_e'(s_axis_tuser) == sss_pkg::OP_STEP) begin
          tstate_d = sss_pkg::T_RD;
        end
      end
      sss_pkg::T_RD: begin
        core_start = 1'b1;
        tstate_d   = sss_pkg::T_BUSY;
      end
      sss_pkg::T_BUSY: begin
        if (core_done) tstate_d = out_free ? sss_pkg::T_IDLE : sss_pkg::T_WAIT;
      end
      sss_pkg::T_WAIT: if (out_free) tstate_d = sss_pkg::T_IDLE;
      default: tstate_d = sss_pkg::T_IDLE;
    endcase
  end

  // latch the step operands at acceptance
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      ops_q.dt   <= s_axis_tdata[70:39];
      ops_q.x    <= s_axis_tdata[102:71];
      ops_q.a    <= s_axis_tdata[134:103];
      ops_q.b    <= s_axis_tdata[166:135];
      ops_q.c    <= s_axis_tdata[198:167];
      ops_q.prev <= '0;
      addr_q     <= s_addr;
      inside_q   <= s_inside;
      last_q     <= s_axis_tlast;
    end
  end

  // memory port: load write at acceptance, step write-back at finish
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = addr_q;
    mem_wdata = core_res.ns;
    if (s_acc && sss_pkg::operation_e'(s_axis_tuser) == sss_pkg::OP_LOAD) begin
      mem_we    = s_inside;
      mem_addr  = s_addr;
      mem_wdata = s_init;
    end else if (fin) begin
      mem_we = inside_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (s_acc) rd_q <= mem[s_addr];
  end

  // arithmetic core
  always_comb begin
    core_ops      = ops_q;
    core_ops.prev = inside_q ? rd_q : '0;
  end

  sss_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (core_start),
    .ops_i   (core_ops),
    .done_o  (core_done),
    .res_o   (core_res)
  );

  // accumulator add with 48-bit saturation
  always_comb begin
    acc_sum = (sss_pkg::V_W + 1)'(acc_q) + (sss_pkg::V_W + 1)'(core_res.nc);
    priority if (acc_sum > sss_pkg::ACC_HI) begin
      acc_sat = sss_pkg::ACC_HI;
    end else if (acc_sum < sss_pkg::ACC_LO) begin
      acc_sat = sss_pkg::ACC_LO;
    end else begin
      acc_sat = acc_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (fin) begin
      acc_q <= last_q ? '0 : acc_sat[47:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (fin) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      m_data_q[31:0]  <= core_res.ns;
      m_data_q[63:32] <= last_q ? sss_pkg::sat32(acc_sat) : '0;
      m_user_q        <= last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // checks
  `SSS_ASSERT_SAME(a_done_in_busy, core_done, tstate_q == sss_pkg::T_BUSY, "core done outside busy")
  `SSS_ASSERT_NEXT(a_acc_cleared, fin && last_q, acc_q == '0, "accumulator not cleared")
  `SSS_ASSERT_SAME(a_y_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[63:32] == '0, "y not zero")

endmodule

// File: src/sss_core.sv
// sss_core: multi-cycle arithmetic of one scan step (softplus, exp, update, output term)
// depends on sss_pkg; one shared registered multiplier, serial divider for ln1p
`timescale 1ns / 1ps

module sss_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  sss_pkg::sss_operands_t ops_i,
  output logic                  done_o,
  output sss_pkg::sss_result_t  res_o
);

  sss_pkg::core_state_e state_q, state_d;

  // latched operands
  logic signed [31:0] dt_q, x_q, a_q, b_q, c_q, prev_q;

  // shared multiplier
  logic signed [sss_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [sss_pkg::PROD_W-1:0] prod_d, prod_q;
  logic signed [sss_pkg::V_W-1:0]    prod_sh;

  // exp and ln1p working registers
  logic signed [sss_pkg::V_W-1:0] ev_q;
  logic                           ret_da_q;
  logic signed [7:0]              n_q;
  logic [29:0]                    u_q;
  logic [30:0]                    term_q;
  logic [32:0]                    sum_q;
  logic [31:0]                    p_q;
  logic [3:0]                     k_q;
  logic [31:0]                    ex_q;
  logic [33:0]                    rem_q;
  logic [29:0]                    w_q;
  logic [29:0]                    w2_q;
  logic [4:0]                     cnt_q;
  logic [31:0]                    lacc_q;

  // update registers
  logic [31:0]                    sp_q;
  logic signed [31:0]             xdt_q, ns_q;
  logic signed [sss_pkg::V_W-1:0] t1_q, nc_q;

  // small-divisor quotient with one correction step
  logic [4:0]  div_d;
  logic [31:0] q_est, q_fix;
  logic [36:0] q_mul, q_rem;

  // ln1p divider step
  logic [33:0] d34, rem2;
  logic        dv_ge;

  // exp final scaling
  logic signed [9:0] sh, nsh;
  logic [5:0]        sft;
  logic [63:0]       rnd;
  logic [31:0]       ef_res;

  // softplus rounding
  logic [32:0] l2, lr;
  logic [31:0] sp_ln;

  assign prod_d  = mul_a * mul_b;
  assign prod_sh = sss_pkg::V_W'(prod_q >>> sss_pkg::FRAC_BITS);

  assign div_d = (state_q == sss_pkg::C_LD || state_q == sss_pkg::C_LC) ?
                 {k_q, 1'b1} : {1'b0, k_q};
  assign q_est = prod_q[63:32];
  assign q_mul = 37'(q_est) * 37'(div_d);
  assign q_rem = 37'(p_q) - q_mul;
  assign q_fix = (q_rem >= 37'(div_d)) ? q_est + 32'd1 : q_est;

  assign d34   = 34'(ex_q) + 34'h0_8000_0000;
  assign rem2  = {rem_q[32:0], 1'b0};
  assign dv_ge = (rem2 >= d34);

  assign l2    = {lacc_q, 1'b0};
  assign lr    = (l2 + 33'(2 ** (29 - sss_pkg::FRAC_BITS))) >> (30 - sss_pkg::FRAC_BITS);
  assign sp_ln = ((dt_q > 32'sd0) ? dt_q : 32'sd0) + lr[31:0];

  // exp scaling by 2^n with rounding and saturation
  always_comb begin
    sh  = {{2{n_q[7]}}, n_q} + (ret_da_q ? 10'(sss_pkg::FRAC_BITS) : 10'd30) - 10'd30;
    nsh = -sh;
    sft = nsh[5:0];
    rnd = (64'(sum_q) + (64'd1 << (sft - 6'd1))) >> sft;
    priority if (sh > 10'sd0) begin
      ef_res = sss_pkg::POS_MAX;
    end else if (sh == 10'sd0) begin
      ef_res = (sum_q > 33'(sss_pkg::POS_MAX)) ? sss_pkg::POS_MAX : sum_q[31:0];
    end else if (nsh >= 10'sd33) begin
      ef_res = '0;
    end else begin
      ef_res = (rnd > 64'(sss_pkg::POS_MAX)) ? sss_pkg::POS_MAX : rnd[31:0];
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sss_pkg::C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and multiplier operands
  always_comb begin
    state_d = state_q;
    mul_a   = '0;
    mul_b   = '0;
    unique case (state_q)
      sss_pkg::C_IDLE: if (start_i) state_d = sss_pkg::C_SP;
      sss_pkg::C_SP:   state_d = (dt_q > sss_pkg::SP_LIMIT) ? sss_pkg::C_X1 : sss_pkg::C_E0;
      sss_pkg::C_E0: begin
        mul_a = sss_pkg::MUL_W'(ev_q);
        mul_b = sss_pkg::LOG2E_Q30;
        if (ev_q > sss_pkg::EXP_LIM || ev_q < -sss_pkg::EXP_LIM) begin
          state_d = sss_pkg::C_ER;
        end else begin
          state_d = sss_pkg::C_E1;
        end
      end
      sss_pkg::C_E1: begin
        mul_a   = sss_pkg::MUL_W'(prod_q[sss_pkg::EXP_TOT-1:sss_pkg::FRAC_BITS]);
        mul_b   = sss_pkg::LN2_Q30;
        state_d = sss_pkg::C_E2;
      end
      sss_pkg::C_E2: state_d = sss_pkg::C_ET;
      sss_pkg::C_ET: begin
        mul_a   = sss_pkg::MUL_W'(term_q);
        mul_b   = sss_pkg::MUL_W'(u_q);
        state_d = sss_pkg::C_EP;
      end
      sss_pkg::C_EP: begin
        mul_a   = sss_pkg::MUL_W'(prod_q[61:30]);
        mul_b   = sss_pkg::MUL_W'(sss_pkg::rcp(div_d));
        state_d = sss_pkg::C_EC;
      end
      sss_pkg::C_EC: begin
        state_d = (k_q == 4'(sss_pkg::EXP_TERMS)) ? sss_pkg::C_EF : sss_pkg::C_ET;
      end
      sss_pkg::C_EF: state_d = sss_pkg::C_ER;
      sss_pkg::C_ER: state_d = ret_da_q ? sss_pkg::C_N1 : sss_pkg::C_DV;
      sss_pkg::C_DV: begin
        if (cnt_q == 5'(sss_pkg::DIV_STEPS - 1)) state_d = sss_pkg::C_LW;
      end
      sss_pkg::C_LW: begin
        mul_a   = sss_pkg::MUL_W'(w_q);
        mul_b   = sss_pkg::MUL_W'(w_q);
        state_d = sss_pkg::C_LW2;
      end
      sss_pkg::C_LW2: state_d = sss_pkg::C_LD;
      sss_pkg::C_LD: begin
        mul_a   = sss_pkg::MUL_W'(p_q);
        mul_b   = sss_pkg::MUL_W'(sss_pkg::rcp(div_d));
        state_d = sss_pkg::C_LC;
      end
      sss_pkg::C_LC: begin
        mul_a   = sss_pkg::MUL_W'(p_q);
        mul_b   = sss_pkg::MUL_W'(w2_q);
        state_d = sss_pkg::C_LP;
      end
      sss_pkg::C_LP: begin
        state_d = (k_q == 4'(sss_pkg::LN_TERMS)) ? sss_pkg::C_LR : sss_pkg::C_LD;
      end
      sss_pkg::C_LR: state_d = sss_pkg::C_X1;
      sss_pkg::C_X1: begin
        mul_a   = sss_pkg::MUL_W'(x_q);
        mul_b   = sss_pkg::MUL_W'(sp_q);
        state_d = sss_pkg::C_X2;
      end
      sss_pkg::C_X2: begin
        mul_a   = sss_pkg::MUL_W'(sp_q);
        mul_b   = sss_pkg::MUL_W'(a_q);
        state_d = sss_pkg::C_X3;
      end
      sss_pkg::C_X3: state_d = sss_pkg::C_E0;
      sss_pkg::C_N1: begin
        mul_a   = sss_pkg::MUL_W'(prev_q);
        mul_b   = sss_pkg::MUL_W'(ex_q);
        state_d = sss_pkg::C_N2;
      end
      sss_pkg::C_N2: begin
        mul_a   = sss_pkg::MUL_W'(b_q);
        mul_b   = sss_pkg::MUL_W'(xdt_q);
        state_d = sss_pkg::C_N3;
      end
      sss_pkg::C_N3: state_d = sss_pkg::C_N4;
      sss_pkg::C_N4: begin
        mul_a   = sss_pkg::MUL_W'(ns_q);
        mul_b   = sss_pkg::MUL_W'(c_q);
        state_d = sss_pkg::C_N5;
      end
      sss_pkg::C_N5:   state_d = sss_pkg::C_DONE;
      sss_pkg::C_DONE: state_d = sss_pkg::C_IDLE;
      default:         state_d = sss_pkg::C_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      sss_pkg::C_IDLE: begin
        if (start_i) begin
          dt_q   <= ops_i.dt;
          x_q    <= ops_i.x;
          a_q    <= ops_i.a;
          b_q    <= ops_i.b;
          c_q    <= ops_i.c;
          prev_q <= ops_i.prev;
        end
      end
      sss_pkg::C_SP: begin
        // large time step passes straight through softplus
        sp_q     <= dt_q;
        ret_da_q <= 1'b0;
        ev_q     <= (dt_q < 32'sd0) ? sss_pkg::V_W'(dt_q) : -sss_pkg::V_W'(dt_q);
      end
      sss_pkg::C_E0: begin
        ex_q <= (ev_q > sss_pkg::EXP_LIM) ? sss_pkg::POS_MAX : '0;
      end
      sss_pkg::C_E1: begin
        n_q <= 8'(prod_q >>> sss_pkg::EXP_TOT);
      end
      sss_pkg::C_E2: begin
        u_q    <= prod_q[59:30];
        term_q <= sss_pkg::ONE_Q30;
        sum_q  <= 33'(sss_pkg::ONE_Q30);
        k_q    <= 4'd1;
      end
      sss_pkg::C_EP: p_q <= prod_q[61:30];
      sss_pkg::C_EC: begin
        // next series term of 2^f
        term_q <= q_fix[30:0];
        sum_q  <= sum_q + 33'(q_fix);
        k_q    <= k_q + 4'd1;
      end
      sss_pkg::C_EF: ex_q <= ef_res;
      sss_pkg::C_ER: begin
        rem_q <= 34'(ex_q);
        cnt_q <= '0;
      end
      sss_pkg::C_DV: begin
        // one quotient bit of z*2^30 / (2+z)
        rem_q <= dv_ge ? rem2 - d34 : rem2;
        w_q   <= {w_q[28:0], dv_ge};
        cnt_q <= cnt_q + 5'd1;
      end
      sss_pkg::C_LW2: begin
        w2_q   <= prod_q[59:30];
        p_q    <= 32'(w_q);
        lacc_q <= '0;
        k_q    <= '0;
      end
      sss_pkg::C_LC: begin
        lacc_q <= lacc_q + q_fix;
        k_q    <= k_q + 4'd1;
      end
      sss_pkg::C_LP: p_q <= prod_q[61:30];
      sss_pkg::C_LR: sp_q <= sp_ln;
      sss_pkg::C_X2: xdt_q <= sss_pkg::sat32((sss_pkg::V_W + 1)'(prod_sh));
      sss_pkg::C_X3: begin
        ev_q     <= prod_sh;
        ret_da_q <= 1'b1;
      end
      sss_pkg::C_N2: t1_q <= prod_sh;
      sss_pkg::C_N3: begin
        ns_q <= sss_pkg::sat32((sss_pkg::V_W + 1)'(t1_q) + (sss_pkg::V_W + 1)'(prod_sh));
      end
      sss_pkg::C_N5: nc_q <= prod_sh;
      default: begin
      end
    endcase
  end

  assign done_o   = (state_q == sss_pkg::C_DONE);
  assign res_o.ns = ns_q;
  assign res_o.nc = nc_q;

endmodule
